### rtl/selective_repeat_receiver_assert.svh
// Assertion macros shared by the selective repeat receiver RTL.
`ifndef SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SRR_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("srr: implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SRR_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("srr: next-cycle check failed");

`endif

### rtl/srr_pkg.sv
// Shared types and constants of the selective repeat receiver.
`default_nettype none
package srr_pkg;

  localparam int unsigned WindowSlots = 32;
  localparam int unsigned WaitDepth   = 16;
  localparam logic [15:0] CapReset    = 16'd1024;

  // Request codes.
  localparam logic [1:0] REQ_SEND = 2'd0;
  localparam logic [1:0] REQ_DATA = 2'd1;
  localparam logic [1:0] REQ_EOF  = 2'd2;
  localparam logic [1:0] REQ_TICK = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_CMD     = 3'd0;
  localparam logic [2:0] KIND_BUSY    = 3'd1;
  localparam logic [2:0] KIND_DONE    = 3'd2;
  localparam logic [2:0] KIND_ACK     = 3'd3;
  localparam logic [2:0] KIND_ACT     = 3'd4;
  localparam logic [2:0] KIND_DELIVER = 3'd5;

  localparam logic [31:0] NoteMissing = 32'hFFFF_FFFE;

  // Result of the shared subtract and compare unit.
  typedef struct packed {
    logic        lt;
    logic [32:0] diff;
  } cmp_t;

endpackage
`default_nettype wire

### rtl/srr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module srr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned Aw = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/srr_cmp.sv
// Shared subtract and compare unit of the receiver sequencer.
`default_nettype none
module srr_cmp (
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output srr_pkg::cmp_t    res_o
);

  logic [32:0] diff;

  // One wide subtract; the borrow gives a less-than.
  assign diff       = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff = diff;
  assign res_o.lt   = diff[32];

endmodule
`default_nettype wire

### rtl/selective_repeat_receiver.sv
// Top level of the selective repeat receiver: sequencer, window and wait queue.
//
// Usage: requests enter on the valid/ready input channel (send request, data,
// end of file, tick); results leave on the valid/ready output channel, one
// per cycle at most, with last_result_o set on the final result of a request.
// The cap on delivered length is written through cfg_we_i/cfg_wdata_i by the
// user only while the block is idle; the block itself does not enforce this.
// Sequence: a request is captured in idle and evaluated in the execute state,
// which registers a single result into the output register. A data packet
// that is stored passes through the store state, and each in-order delivery
// then takes a slot check and a slot read of the window RAM, followed by the
// closing ack. A completing end of file passes through the done state and,
// when senders wait, the activation of the next waiting sender.
// Flow control: one request at a time; in_ready_o is high only in idle, so a
// new request is taken only after the previous one is finished.
// Reset clears the session, the window valid bits and the wait queue; the
// cap returns to 1024. When the output side stalls, the sequencer holds its
// state and the pending result until the output register is free.
`default_nettype none
module selective_repeat_receiver #(
  parameter int unsigned WINDOW_SLOTS = srr_pkg::WindowSlots,
  parameter int unsigned WAIT_DEPTH   = srr_pkg::WaitDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] sender_id_i,
  input  wire logic [30:0] seq_num_i,
  input  wire logic [31:0] payload_ref_i,
  input  wire logic [15:0] payload_len_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       out_kind_o,
  output logic [31:0]      dest_id_o,
  output logic [31:0]      ack_seq_o,
  output logic [31:0]      ack_note_o,
  output logic [31:0]      deliver_ref_o,
  output logic [15:0]      deliver_len_o,
  output logic             queue_overflow_o,
  output logic             last_result_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  localparam int unsigned SlotAw = $clog2(WINDOW_SLOTS);
  localparam int unsigned WaitAw = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned CntW   = $clog2(WAIT_DEPTH + 1);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_EXEC      = 4'd1;
  localparam logic [3:0] ST_STORE     = 4'd2;
  localparam logic [3:0] ST_DRAIN_CHK = 4'd3;
  localparam logic [3:0] ST_DRAIN_OUT = 4'd4;
  localparam logic [3:0] ST_ACK       = 4'd5;
  localparam logic [3:0] ST_DONE_EOF  = 4'd6;
  localparam logic [3:0] ST_ACT_EOF   = 4'd7;

  logic [3:0] state_q, state_d;

  // Captured request.
  logic [1:0]  req_q;
  logic [31:0] sender_q;
  logic [30:0] seq_q;
  logic [31:0] ref_q;
  logic [15:0] len_q;

  // Session and queue state.
  logic [15:0]             cap_q;
  logic                    sv_q, sv_d;
  logic [31:0]             sid_q, sid_d;
  logic                    conn_q, conn_d;
  logic [31:0]             ne_q, ne_d;
  logic [SlotAw-1:0]       head_q, head_d;
  logic [31:0]             ack_dest_q, ack_dest_d;
  logic [WINDOW_SLOTS-1:0] valid_q, valid_d;
  logic [WaitAw-1:0]       whead_q, whead_d;
  logic [WaitAw-1:0]       wtail_q, wtail_d;
  logic [CntW-1:0]         wcount_q, wcount_d;
  logic [SlotAw-1:0]       slot_q, slot_d;
  logic                    hit_q, hit_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [2:0]  kind_q, kind_d;
  logic [31:0] dest_q, dest_d;
  logic [31:0] aseq_q, aseq_d;
  logic [31:0] note_q, note_d;
  logic [31:0] dref_q, dref_d;
  logic [15:0] dlen_q, dlen_d;
  logic        ovf_q, ovf_d;
  logic        last_q, last_d;

  logic          emit;
  logic          push;
  logic          out_free;
  logic          ours;
  logic [31:0]   cmp_a, cmp_b;
  srr_pkg::cmp_t cmp_res;
  logic          in_win;
  logic          eof_match;
  logic [SlotAw:0] slot_sum;
  logic [SlotAw:0] slot_wrap;
  logic [47:0]   slot_rdata;
  logic [31:0]   fifo_rdata;
  logic [15:0]   slot_len;

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign ours       = sv_q && (sid_q == sender_q);

  // Shared compare unit: end of file measures next_expected against seq,
  // data measures seq against next_expected.
  always_comb begin
    if (req_q == srr_pkg::REQ_EOF) begin
      cmp_a = ne_q;
      cmp_b = {1'b0, seq_q};
    end else begin
      cmp_a = {1'b0, seq_q};
      cmp_b = ne_q;
    end
  end

  srr_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  assign in_win    = !cmp_res.lt && (cmp_res.diff < 33'(WINDOW_SLOTS));
  assign eof_match = !cmp_res.lt && (cmp_res.diff == 33'd1);
  assign slot_sum  = {1'b0, head_q} + {1'b0, cmp_res.diff[SlotAw-1:0]};
  assign slot_wrap = (slot_sum >= (SlotAw + 1)'(WINDOW_SLOTS)) ?
                     slot_sum - (SlotAw + 1)'(WINDOW_SLOTS) : slot_sum;
  assign slot_len  = (slot_rdata[15:0] < cap_q) ? slot_rdata[15:0] : cap_q;

  // Window storage: handle and length per slot.
  srr_ram #(.WIDTH(48), .DEPTH(WINDOW_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_STORE),
    .waddr_i (slot_q),
    .wdata_i ({ref_q, len_q}),
    .raddr_i (head_q),
    .rdata_o (slot_rdata)
  );

  // Wait queue storage.
  srr_ram #(.WIDTH(32), .DEPTH(WAIT_DEPTH)) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wtail_q),
    .wdata_i (sender_q),
    .raddr_i (whead_q),
    .rdata_o (fifo_rdata)
  );

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    sv_d       = sv_q;
    sid_d      = sid_q;
    conn_d     = conn_q;
    ne_d       = ne_q;
    head_d     = head_q;
    ack_dest_d = ack_dest_q;
    valid_d    = valid_q;
    whead_d    = whead_q;
    wtail_d    = wtail_q;
    wcount_d   = wcount_q;
    slot_d     = slot_q;
    hit_d      = hit_q;
    push       = 1'b0;
    emit       = 1'b0;
    kind_d     = srr_pkg::KIND_CMD;
    dest_d     = 32'd0;
    aseq_d     = 32'd0;
    note_d     = 32'd0;
    dref_d     = 32'd0;
    dlen_d     = 16'd0;
    ovf_d      = 1'b0;
    last_d     = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (req_q)
          srr_pkg::REQ_SEND: begin
            if (out_free) begin
              emit    = 1'b1;
              dest_d  = sender_q;
              state_d = ST_IDLE;
              if (!sv_q || sid_q == sender_q) begin
                sv_d       = 1'b1;
                sid_d      = sender_q;
                conn_d     = 1'b1;
                ack_dest_d = sender_q;
                kind_d     = srr_pkg::KIND_CMD;
              end else if (wcount_q >= CntW'(WAIT_DEPTH)) begin
                kind_d = srr_pkg::KIND_BUSY;
                ovf_d  = 1'b1;
              end else begin
                kind_d   = srr_pkg::KIND_BUSY;
                push     = 1'b1;
                wtail_d  = (wtail_q == WaitAw'(WAIT_DEPTH - 1)) ? '0 : wtail_q + 1'b1;
                wcount_d = wcount_q + 1'b1;
              end
            end
          end
          srr_pkg::REQ_DATA: begin
            if (!ours) begin
              if (out_free) begin
                emit    = 1'b1;
                kind_d  = srr_pkg::KIND_DONE;
                dest_d  = sender_q;
                state_d = ST_IDLE;
              end
            end else if (cmp_res.lt) begin
              state_d = ST_IDLE;
            end else if (in_win) begin
              slot_d  = slot_wrap[SlotAw-1:0];
              hit_d   = (cmp_res.diff == 33'd0);
              state_d = ST_STORE;
            end else begin
              state_d = ST_ACK;
            end
          end
          srr_pkg::REQ_EOF: begin
            if (!ours) begin
              if (out_free) begin
                emit    = 1'b1;
                kind_d  = srr_pkg::KIND_DONE;
                dest_d  = sender_q;
                state_d = ST_IDLE;
              end
            end else if (eof_match) begin
              state_d = ST_DONE_EOF;
            end else if (out_free) begin
              emit    = 1'b1;
              kind_d  = srr_pkg::KIND_ACK;
              dest_d  = ack_dest_q;
              aseq_d  = ne_q - 32'd1;
              note_d  = srr_pkg::NoteMissing;
              state_d = ST_IDLE;
            end
          end
          default: begin
            // Timeout tick.
            if (sv_q && !conn_q) begin
              if (out_free) begin
                emit    = 1'b1;
                kind_d  = srr_pkg::KIND_ACT;
                dest_d  = sid_q;
                state_d = ST_IDLE;
              end
            end else if (sv_q && ne_q != 32'd0) begin
              if (out_free) begin
                emit    = 1'b1;
                kind_d  = srr_pkg::KIND_ACK;
                dest_d  = ack_dest_q;
                aseq_d  = ne_q - 32'd1;
                note_d  = srr_pkg::NoteMissing;
                state_d = ST_IDLE;
              end
            end else begin
              state_d = ST_IDLE;
            end
          end
        endcase
      end
      ST_STORE: begin
        valid_d[slot_q] = 1'b1;
        state_d = hit_q ? ST_DRAIN_CHK : ST_ACK;
      end
      ST_DRAIN_CHK: begin
        state_d = valid_q[head_q] ? ST_DRAIN_OUT : ST_ACK;
      end
      ST_DRAIN_OUT: begin
        if (out_free) begin
          emit            = 1'b1;
          last_d          = 1'b0;
          kind_d          = srr_pkg::KIND_DELIVER;
          dest_d          = sid_q;
          dref_d          = slot_rdata[47:16];
          dlen_d          = slot_len;
          valid_d[head_q] = 1'b0;
          head_d = (head_q == SlotAw'(WINDOW_SLOTS - 1)) ? '0 : head_q + 1'b1;
          ne_d            = ne_q + 32'd1;
          state_d         = ST_DRAIN_CHK;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          emit    = 1'b1;
          kind_d  = srr_pkg::KIND_ACK;
          dest_d  = ack_dest_q;
          aseq_d  = ne_q - 32'd1;
          note_d  = {1'b0, seq_q};
          state_d = ST_IDLE;
        end
      end
      ST_DONE_EOF: begin
        if (out_free) begin
          emit    = 1'b1;
          kind_d  = srr_pkg::KIND_DONE;
          dest_d  = ack_dest_q;
          last_d  = (wcount_q == '0);
          valid_d = '0;
          ne_d    = 32'd0;
          head_d  = '0;
          conn_d  = 1'b0;
          if (wcount_q == '0) begin
            sv_d    = 1'b0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_ACT_EOF;
          end
        end
      end
      ST_ACT_EOF: begin
        if (out_free) begin
          emit     = 1'b1;
          kind_d   = srr_pkg::KIND_ACT;
          dest_d   = fifo_rdata;
          sid_d    = fifo_rdata;
          whead_d  = (whead_q == WaitAw'(WAIT_DEPTH - 1)) ? '0 : whead_q + 1'b1;
          wcount_d = wcount_q - 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= srr_pkg::CapReset;
      sv_q        <= 1'b0;
      sid_q       <= 32'd0;
      conn_q      <= 1'b0;
      ne_q        <= 32'd0;
      head_q      <= '0;
      ack_dest_q  <= 32'd0;
      valid_q     <= '0;
      whead_q     <= '0;
      wtail_q     <= '0;
      wcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      sv_q        <= sv_d;
      sid_q       <= sid_d;
      conn_q      <= conn_d;
      ne_q        <= ne_d;
      head_q      <= head_d;
      ack_dest_q  <= ack_dest_d;
      valid_q     <= valid_d;
      whead_q     <= whead_d;
      wtail_q     <= wtail_d;
      wcount_q    <= wcount_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request capture, window bookkeeping and result payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q    <= req_type_i;
      sender_q <= sender_id_i;
      seq_q    <= seq_num_i;
      ref_q    <= payload_ref_i;
      len_q    <= payload_len_i;
    end
    slot_q <= slot_d;
    hit_q  <= hit_d;
    if (emit) begin
      kind_q <= kind_d;
      dest_q <= dest_d;
      aseq_q <= aseq_d;
      note_q <= note_d;
      dref_q <= dref_d;
      dlen_q <= dlen_d;
      ovf_q  <= ovf_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = kind_q;
  assign dest_id_o        = dest_q;
  assign ack_seq_o        = aseq_q;
  assign ack_note_o       = note_q;
  assign deliver_ref_o    = dref_q;
  assign deliver_len_o    = dlen_q;
  assign queue_overflow_o = ovf_q;
  assign last_result_o    = last_q;

  `include "selective_repeat_receiver_assert.svh"

  // The wait queue never counts more senders than it holds.
  `SRR_ASSERT_IMPL(a_wait_count, clk_i, rst_ni, 1'b1, wcount_q <= CntW'(WAIT_DEPTH))
  // With no sender served, the window is empty and at its origin.
  `SRR_ASSERT_IMPL(a_idle_window, clk_i, rst_ni, !sv_q, ne_q == 32'd0 && valid_q == '0)
  // A delivery is only read from a slot that holds a packet.
  `SRR_ASSERT_IMPL(a_drain_valid, clk_i, rst_ni, state_q == ST_DRAIN_OUT, valid_q[head_q])

endmodule
`default_nettype wire
